// ===== rtl/core/double_ended_queue_defines.svh =====
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DEQ_ASSERT(label, prop, msg)
`define DEQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int OPCODE_W   = 3;
	localparam int DATA_IN_W  = 32;
	localparam int DATA_OUT_W = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;

	localparam int IN_BITS    = OPCODE_W + DATA_IN_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = DATA_OUT_W + STATUS_W + COUNT_W + 2;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_HEAD = 3'd0,
		OP_PUSH_TAIL = 3'd1,
		OP_POP_HEAD  = 3'd2,
		OP_POP_TAIL  = 3'd3,
		OP_PEEK_HEAD = 3'd4,
		OP_PEEK_TAIL = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic shift_in;
		logic shift_out;
		logic tail_put;
		logic tail_take;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// The result word of an accepted input word is registered and valid in the next cycle.
// Throughput: one word per cycle while m_tready is high; each op is one cell-row step.
// Storage is a row of DEPTH cells that shift toward head or tail; the tail is found
// from the cells' valid bits.
// Reset (arst_n low, asynchronous) empties the queue and drops any pending result.
module double_ended_queue
	import deq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // opcode, data_in
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // data_out, status, count, is_empty, is_full
);

`include "double_ended_queue_defines.svh"

	logic [OPCODE_W-1:0]  opcode;
	logic [DATA_IN_W-1:0] data_in;
	word_t                word;
	logic                 accept;
	logic                 empty;
	logic                 full;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             m_tvalid_q;
	logic [OUT_BITS-1:0] result_q;

	cell_ctrl_t ctrl;
	word_t      cell_data  [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_tail;
	word_t      head_word;
	word_t      tail_word;

	logic [DATA_OUT_W-1:0] data_out;
	status_t               status;

	assign opcode  = s_tdata[OPCODE_W-1:0];
	assign data_in = s_tdata[OPCODE_W +: DATA_IN_W];
	assign word    = DATA_WIDTH'(data_in);

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));

	always_comb begin
		ctrl      = '0;
		count_nxt = count_q;
		data_out  = '0;
		status    = ST_OK;
		unique case (opcode)
			OP_PUSH_HEAD: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.shift_in = accept;
					count_nxt     = count_q + 1'b1;
				end
			end
			OP_PUSH_TAIL: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctrl.tail_put = accept;
					count_nxt     = count_q + 1'b1;
				end
			end
			OP_POP_HEAD: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctrl.shift_out = accept;
					count_nxt      = count_q - 1'b1;
					data_out       = DATA_OUT_W'(head_word);
				end
			end
			OP_POP_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					ctrl.tail_take = accept;
					count_nxt      = count_q - 1'b1;
					data_out       = DATA_OUT_W'(tail_word);
				end
			end
			OP_PEEK_HEAD: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					data_out = DATA_OUT_W'(head_word);
				end
			end
			OP_PEEK_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					data_out = DATA_OUT_W'(tail_word);
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_data;
		logic  left_valid;
		word_t right_data;
		logic  right_valid;

		if (i == 0) begin : g_first
			assign left_data  = word;
			assign left_valid = 1'b1;
		end else begin : g_mid_l
			assign left_data  = cell_data[i-1];
			assign left_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data  = '0;
			assign right_valid = 1'b0;
		end else begin : g_mid_r
			assign right_data  = cell_data[i+1];
			assign right_valid = cell_valid[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.word        (word),
			.left_data   (left_data),
			.left_valid  (left_valid),
			.right_data  (right_data),
			.right_valid (right_valid),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.is_tail     (cell_tail[i])
		);
	end

	assign head_word = cell_data[0];

	always_comb begin
		tail_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_word = tail_word | (cell_data[i] & {DATA_WIDTH{cell_tail[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= {count_nxt == CNT_W'(DEPTH), count_nxt == '0,
				COUNT_W'(count_nxt), status, data_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(result_q);

	`DEQ_ASSERT(a_count_matches_cells, count_q == CNT_W'($countones(cell_valid)), "count differs from occupied cells")
	`DEQ_ASSERT(a_cells_packed, (cell_valid & (cell_valid + 1'b1)) == '0, "occupied cells not packed from head")
	`DEQ_ASSERT(a_one_tail, empty ? (cell_tail == '0) : $onehot(cell_tail), "tail cell not unique")
	`DEQ_ASSERT_NEXT(a_push_grows, accept && !full && (opcode == OP_PUSH_HEAD || opcode == OP_PUSH_TAIL), count_q == $past(count_q) + 1'b1, "push did not grow queue")
	`DEQ_ASSERT_NEXT(a_pop_empty_status, accept && empty && (opcode == OP_POP_HEAD || opcode == OP_POP_TAIL), result_q[DATA_OUT_W +: STATUS_W] == ST_EMPTY, "pop on empty queue not flagged")

endmodule

// ===== rtl/core/deq_cell.sv =====
module deq_cell
	import deq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  word_t      word,
	input  word_t      left_data,
	input  logic       left_valid,
	input  word_t      right_data,
	input  logic       right_valid,
	output word_t      data,
	output logic       valid,
	output logic       is_tail
);

	word_t data_q;
	logic  valid_q;

	assign data    = data_q;
	assign valid   = valid_q;
	assign is_tail = valid_q && !right_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift_in) begin
			valid_q <= left_valid;
		end else if (ctrl.shift_out) begin
			valid_q <= right_valid;
		end else if (ctrl.tail_put && !valid_q && left_valid) begin
			valid_q <= 1'b1;
		end else if (ctrl.tail_take && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_in) begin
			data_q <= left_data;
		end else if (ctrl.shift_out) begin
			data_q <= right_data;
		end else if (ctrl.tail_put && !valid_q && left_valid) begin
			data_q <= word;
		end
	end

endmodule
